[hdl/shws_pkg.sv]
// shws_pkg: shared constants, widths and transaction structs for the
// spectrum history weighted smoother; no dependencies
package shws_pkg;

  // sizing
  localparam int HISTORY_DEPTH = 32;
  localparam int NUM_BINS      = 128;

  // fixed field widths
  localparam int BIN_W  = 7;
  localparam int VAL_W  = 16;
  localparam int SUM_W  = 21;

  // derived widths
  localparam int POS_W      = $clog2(HISTORY_DEPTH + 1);
  localparam int SLOT_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int BIN_AW     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int HIST_WORDS = NUM_BINS * HISTORY_DEPTH;
  localparam int HIST_AW    = (HIST_WORDS > 1) ? $clog2(HIST_WORDS) : 1;
  localparam int BSTATE_W   = POS_W + SLOT_W;

  // weights are Q0.16 plus one integer bit for the exact 1.0
  localparam int WGT_FRAC = 16;
  localparam int WGT_W    = WGT_FRAC + 1;
  localparam int P4_W     = 4 * POS_W;
  localparam int NUM_W    = P4_W + WGT_W;
  localparam int PROD_W   = VAL_W + WGT_W;

  // item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // history walk step from the controller
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [POS_W-1:0] pos;
  } shws_tok_t;

  // history value paired with its weight
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [VAL_W-1:0] value;
    logic [WGT_W-1:0] weight;
  } shws_wtok_t;

  // accumulator status back to the controller
  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] sum;
  } shws_mac_stat_t;

endpackage

[hdl/shws_ram.sv]
// shws_ram: generic single write port, single read port ram with
// registered read data; no dependencies
module shws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/shws_wgt.sv]
// shws_wgt: ramp weight pipeline, pos^4 by two squarings then a restoring
// divider with one quotient bit per stage; depends on shws_pkg
module shws_wgt import shws_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  shws_tok_t        tok,
  input  logic [VAL_W-1:0] hist_rdata,
  input  logic [P4_W-1:0]  den,
  output shws_wtok_t       wtok
);

  // front stages
  logic                 v0_r, v1_r, v2_r;
  logic                 l0_r, l1_r, l2_r;
  logic [POS_W-1:0]     p0_r;
  logic [2*POS_W-1:0]   sq1_r;
  logic [P4_W-1:0]      p4_r;
  logic [VAL_W-1:0]     val1_r, val2_r;

  // divider stages, index 0 holds the rounded numerator
  logic [NUM_W-1:0]     rem_r [0:WGT_W];
  logic [WGT_W-1:0]     q_r   [0:WGT_W];
  logic [VAL_W-1:0]     dv_r  [0:WGT_W];
  logic [WGT_W:0]       dvld_r;
  logic [WGT_W:0]       dlast_r;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      dvld_r <= '0;
    end else begin
      v0_r   <= tok.valid;
      v1_r   <= v0_r;
      v2_r   <= v1_r;
      dvld_r <= {dvld_r[WGT_W-1:0], v2_r};
    end
  end

  // pos^4 and the value lined up with the ram read
  always_ff @(posedge clk) begin
    l0_r    <= tok.last;
    p0_r    <= tok.pos;
    l1_r    <= l0_r;
    sq1_r   <= (2*POS_W)'(p0_r) * (2*POS_W)'(p0_r);
    val1_r  <= hist_rdata;
    l2_r    <= l1_r;
    p4_r    <= P4_W'(sq1_r) * P4_W'(sq1_r);
    val2_r  <= val1_r;
    dlast_r <= {dlast_r[WGT_W-1:0], l2_r};
  end

  // numerator with half the divisor added for round to nearest
  always_ff @(posedge clk) begin
    rem_r[0] <= (NUM_W'(p4_r) << WGT_FRAC) + NUM_W'(den >> 1);
    q_r[0]   <= '0;
    dv_r[0]  <= val2_r;
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k <= WGT_W; k++) begin : g_div
    logic [NUM_W-1:0] trial;
    logic             fit;

    assign trial = NUM_W'(den) << (WGT_W - k);
    assign fit   = (rem_r[k-1] >= trial);

    always_ff @(posedge clk) begin
      rem_r[k] <= fit ? (rem_r[k-1] - trial) : rem_r[k-1];
      q_r[k]   <= q_r[k-1] | (fit ? (WGT_W'(1) << (WGT_W - k)) : '0);
      dv_r[k]  <= dv_r[k-1];
    end
  end

  assign wtok.valid  = dvld_r[WGT_W];
  assign wtok.last   = dlast_r[WGT_W];
  assign wtok.value  = dv_r[WGT_W];
  assign wtok.weight = q_r[WGT_W];

endmodule

[hdl/shws_mac.sv]
// shws_mac: multiply history values by their weights, truncate and
// accumulate; depends on shws_pkg
module shws_mac import shws_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           clear,
  input  shws_wtok_t     wtok,
  output shws_mac_stat_t stat
);

  logic              mv_r;
  logic              ml_r;
  logic [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]  acc_r;
  logic              done_r;

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mv_r   <= wtok.valid;
      done_r <= mv_r && ml_r;
    end
  end

  // product register, then truncated accumulate
  always_ff @(posedge clk) begin
    ml_r   <= wtok.last;
    prod_r <= PROD_W'(wtok.value) * PROD_W'(wtok.weight);
    if (clear) begin
      acc_r <= '0;
    end else if (mv_r) begin
      acc_r <= acc_r + SUM_W'(prod_r >> WGT_FRAC);
    end
  end

  assign stat.done = done_r;
  assign stat.sum  = acc_r;

endmodule

[hdl/shws_ctrl.sv]
// shws_ctrl: item sequencer, per-bin fill and slot bookkeeping, history
// write and walk, result register; depends on shws_pkg
module shws_ctrl import shws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [BIN_W-1:0]     in_bin_index,
  input  logic [VAL_W-1:0]     in_sample_value,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BIN_W-1:0]     out_bin,
  output logic [SUM_W-1:0]     out_smoothed_value,
  // bin state ram
  output logic                 bs_we,
  output logic [BIN_AW-1:0]    bs_waddr,
  output logic [BSTATE_W-1:0]  bs_wdata,
  output logic [BIN_AW-1:0]    bs_raddr,
  input  logic [BSTATE_W-1:0]  bs_rdata,
  // history ram
  output logic                 h_we,
  output logic [HIST_AW-1:0]   h_waddr,
  output logic [VAL_W-1:0]     h_wdata,
  output logic [HIST_AW-1:0]   h_raddr,
  // datapath
  output shws_tok_t            tok,
  output logic [P4_W-1:0]      den,
  output logic                 mac_clear,
  input  shws_mac_stat_t       mac_stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STATE,
    S_SQ,
    S_P4,
    S_WALK,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [NUM_BINS-1:0]  bvalid_r, bvalid_nxt;
  logic [BIN_W-1:0]     bin_r, bin_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic [HIST_AW-1:0]   base_r, base_nxt;
  logic [POS_W-1:0]     n_r, n_nxt;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic [POS_W-1:0]     j_r, j_nxt;
  logic [2*POS_W-1:0]   nsq_r, nsq_nxt;
  logic [P4_W-1:0]      den_r, den_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BIN_W-1:0]     out_bin_r, out_bin_nxt;
  logic [SUM_W-1:0]     out_sum_r, out_sum_nxt;

  logic                 in_range;
  logic [BIN_AW-1:0]    bin_addr;
  logic [POS_W-1:0]     cur_fill;
  logic [SLOT_W-1:0]    cur_slot;
  logic [POS_W-1:0]     new_fill;
  logic [SLOT_W-1:0]    new_slot;
  logic [POS_W:0]       old_raw;
  logic [SLOT_W-1:0]    oldest;
  logic                 walk_last;

  assign in_range = (32'(in_bin_index) < 32'(NUM_BINS));
  assign bin_addr = BIN_AW'(bin_r);

  // bin state read is launched with the accepted transaction
  assign bs_raddr = BIN_AW'(in_bin_index);

  // bin state, a never-touched bin reads as empty
  assign cur_fill = bvalid_r[bin_addr] ? bs_rdata[BSTATE_W-1 -: POS_W] : '0;
  assign cur_slot = bvalid_r[bin_addr] ? bs_rdata[SLOT_W-1:0] : '0;

  // ring update and oldest entry after the write
  assign new_fill = (cur_fill == POS_W'(HISTORY_DEPTH)) ? cur_fill : cur_fill + POS_W'(1);
  assign new_slot = (cur_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : cur_slot + SLOT_W'(1);
  assign old_raw  = (POS_W+1)'(new_slot) + (POS_W+1)'(HISTORY_DEPTH) - (POS_W+1)'(new_fill);
  assign oldest   = (old_raw >= (POS_W+1)'(HISTORY_DEPTH))
                    ? SLOT_W'(old_raw - (POS_W+1)'(HISTORY_DEPTH))
                    : SLOT_W'(old_raw);

  assign walk_last = (j_r == n_r - POS_W'(1));

  // ram ports
  assign bs_waddr = bin_addr;
  assign bs_wdata = {new_fill, new_slot};
  assign h_waddr  = base_r + HIST_AW'(cur_slot);
  assign h_wdata  = val_r;
  assign h_raddr  = base_r + HIST_AW'(idx_r);

  assign in_ready           = (state_r == S_IDLE);
  assign den                = den_r;
  assign out_valid          = out_valid_r;
  assign out_bin            = out_bin_r;
  assign out_smoothed_value = out_sum_r;

  // next state
  always_comb begin
    state_nxt     = state_r;
    bvalid_nxt    = bvalid_r;
    bin_nxt       = bin_r;
    val_nxt       = val_r;
    base_nxt      = base_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    nsq_nxt       = nsq_r;
    den_nxt       = den_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_bin_nxt   = out_bin_r;
    out_sum_nxt   = out_sum_r;
    bs_we         = 1'b0;
    h_we          = 1'b0;
    mac_clear     = 1'b0;
    tok           = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_CLEAR) begin
            bvalid_nxt = '0;
          end else if (in_range) begin
            bin_nxt   = in_bin_index;
            val_nxt   = in_sample_value;
            base_nxt  = HIST_AW'(in_bin_index) * HIST_AW'(HISTORY_DEPTH);
            state_nxt = S_STATE;
          end
        end
      end
      S_STATE: begin
        // store the sample and advance the ring
        h_we                 = 1'b1;
        bs_we                = 1'b1;
        bvalid_nxt[bin_addr] = 1'b1;
        n_nxt                = new_fill;
        idx_nxt              = oldest;
        j_nxt                = '0;
        state_nxt            = S_SQ;
      end
      S_SQ: begin
        nsq_nxt   = (2*POS_W)'(n_r) * (2*POS_W)'(n_r);
        state_nxt = S_P4;
      end
      S_P4: begin
        den_nxt   = P4_W'(nsq_r) * P4_W'(nsq_r);
        mac_clear = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        // oldest to newest, one entry per cycle
        tok.valid = 1'b1;
        tok.last  = walk_last;
        tok.pos   = j_r + POS_W'(1);
        idx_nxt   = (idx_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : idx_r + SLOT_W'(1);
        j_nxt     = j_r + POS_W'(1);
        if (walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (mac_stat.done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_bin_nxt   = bin_r;
          out_sum_nxt   = mac_stat.sum;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bvalid_r    <= bvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bin_r     <= bin_nxt;
    val_r     <= val_nxt;
    base_r    <= base_nxt;
    n_r       <= n_nxt;
    idx_r     <= idx_nxt;
    j_r       <= j_nxt;
    nsq_r     <= nsq_nxt;
    den_r     <= den_nxt;
    out_bin_r <= out_bin_nxt;
    out_sum_r <= out_sum_nxt;
  end

endmodule

[hdl/spectrum_history_weighted_smoother.sv]
// spectrum_history_weighted_smoother: top level, per-bin history rams,
// controller, weight divider pipeline and accumulator; depends on shws_pkg
//
// Usage
//   Input channel (in_valid/in_ready): a transaction is either a sample
//   (in_kind = 0) for bin in_bin_index with magnitude in_sample_value, or a
//   clear (in_kind = 1) that empties every bin's history and gives no result.
//   A sample whose bin is out of range is dropped without a result.
//   Result channel (out_valid/out_ready): one transaction per sample with the
//   bin and the fourth-power ramp weighted sum of its history.
//   Timing: one item at a time. A sample's result enters the output register
//   once its history walk and accumulate have finished and the register is
//   free. The input is ready again in that same cycle, so a new sample is
//   accepted only after the previous one has left the sequencer.
//   The history walk through the single ram read port, plus the depth of
//   the weight divider and multiply-accumulate pipeline, sets the time per sample.
//   Clear and dropped items give no result and leave the input ready.
//   Reset: rst_n low for one clock empties every bin; history ram contents
//   are never cleared, only the per-bin fill state is.
//   Stall: a finished result waits in the output register while the next
//   transaction is accepted; a second result holds the sequencer until the
//   output register is free.
module spectrum_history_weighted_smoother import shws_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_kind,
  input  logic [BIN_W-1:0] in_bin_index,
  input  logic [VAL_W-1:0] in_sample_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [BIN_W-1:0] out_bin,
  output logic [SUM_W-1:0] out_smoothed_value
);

  logic                bs_we;
  logic [BIN_AW-1:0]   bs_waddr;
  logic [BSTATE_W-1:0] bs_wdata;
  logic [BIN_AW-1:0]   bs_raddr;
  logic [BSTATE_W-1:0] bs_rdata;
  logic                h_we;
  logic [HIST_AW-1:0]  h_waddr;
  logic [VAL_W-1:0]    h_wdata;
  logic [HIST_AW-1:0]  h_raddr;
  logic [VAL_W-1:0]    h_rdata;
  shws_tok_t           tok;
  shws_wtok_t          wtok;
  logic [P4_W-1:0]     den;
  logic                mac_clear;
  shws_mac_stat_t      mac_stat;

  // per-bin fill count and write slot
  shws_ram #(
    .WIDTH (BSTATE_W),
    .DEPTH (NUM_BINS)
  ) u_bs_ram (
    .clk   (clk),
    .we    (bs_we),
    .waddr (bs_waddr),
    .wdata (bs_wdata),
    .raddr (bs_raddr),
    .rdata (bs_rdata)
  );

  // history rings, one block of HISTORY_DEPTH words per bin
  shws_ram #(
    .WIDTH (VAL_W),
    .DEPTH (HIST_WORDS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // sequencer
  shws_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_bin_index       (in_bin_index),
    .in_sample_value    (in_sample_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_bin            (out_bin),
    .out_smoothed_value (out_smoothed_value),
    .bs_we              (bs_we),
    .bs_waddr           (bs_waddr),
    .bs_wdata           (bs_wdata),
    .bs_raddr           (bs_raddr),
    .bs_rdata           (bs_rdata),
    .h_we               (h_we),
    .h_waddr            (h_waddr),
    .h_wdata            (h_wdata),
    .h_raddr            (h_raddr),
    .tok                (tok),
    .den                (den),
    .mac_clear          (mac_clear),
    .mac_stat           (mac_stat)
  );

  // weight per history position
  shws_wgt u_wgt (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok        (tok),
    .hist_rdata (h_rdata),
    .den        (den),
    .wtok       (wtok)
  );

  // weighted sum
  shws_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (mac_clear),
    .wtok  (wtok),
    .stat  (mac_stat)
  );

endmodule

[hdl/shws_checker.sv]
// shws_checker: port-level checks for the smoother, bound to the top
// level; depends on shws_pkg
module shws_checker import shws_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_kind,
  input logic [BIN_W-1:0] in_bin_index,
  input logic             out_valid,
  input logic             out_ready,
  input logic [BIN_W-1:0] out_bin,
  input logic [SUM_W-1:0] out_smoothed_value
);

  logic in_take_sample;
  logic in_take_clear;

  assign in_take_sample = in_valid && in_ready && (in_kind == KIND_SAMPLE)
                          && (32'(in_bin_index) < 32'(NUM_BINS));
  assign in_take_clear  = in_valid && in_ready && (in_kind == KIND_CLEAR);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bin)
                                && $stable(out_smoothed_value))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a sample busies the block and its result cannot appear at once
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take_sample |=> !in_ready && !$rose(out_valid))
    else $error("sample transaction did not start the walk");

  // a clear stays ready and produces nothing
  a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_take_clear |=> in_ready && !$rose(out_valid))
    else $error("clear transaction produced a result or stalled");

endmodule

bind spectrum_history_weighted_smoother shws_checker u_shws_checker (.*);

[dv/spectrum_history_weighted_smoother_tb.sv]
// spectrum_history_weighted_smoother_tb: self-checking testbench with its own per-bin
// history predictor, valid/ready driver with bursts and a stalling result sink;
// depends on shws_pkg and spectrum_history_weighted_smoother
`timescale 1ns / 1ps

module spectrum_history_weighted_smoother_tb;
  import shws_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 392;

  // one expected result transaction
  typedef struct {
    logic [BIN_W-1:0] bin;
    logic [SUM_W-1:0] sum;
  } smoothed_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_kind = KIND_SAMPLE;
  logic [BIN_W-1:0] in_bin_index = '0;
  logic [VAL_W-1:0] in_sample_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [BIN_W-1:0] out_bin;
  logic [SUM_W-1:0] out_smoothed_value;

  // predictor state: per-bin ring of magnitudes, fill and next write slot
  logic [VAL_W-1:0] hist_mem [NUM_BINS][HISTORY_DEPTH];
  int unsigned      fill_of [NUM_BINS];
  int unsigned      slot_of [NUM_BINS];

  smoothed_t smoothed_q[$];
  int        mismatches = 0;
  int        n_samples = 0;
  int        n_clears = 0;
  int        n_results = 0;

  // sender pacing
  int burst_left = 0;
  bit quiet = 1'b0;

  // receiver pacing and long hold-off request
  bit hold_request = 1'b0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_phase = 0;

  spectrum_history_weighted_smoother i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_bin_index       (in_bin_index),
    .in_sample_value    (in_sample_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_bin            (out_bin),
    .out_smoothed_value (out_smoothed_value)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // numerator of the q0.16 weight (pos/n)^4 plus n^4/2: round to nearest, halves up
  function automatic longint unsigned ramp_q16(input int unsigned pos, input int unsigned n);
    longint unsigned p;
    longint unsigned d;
    longint unsigned den;
    p   = pos;
    d   = n;
    den = d * d * d * d;
    return ((p * p * p * p) << WGT_FRAC) + den / 2;
  endfunction

  // append a magnitude to a bin and return the weighted history sum
  function automatic logic [SUM_W-1:0] smooth_bin(input logic [BIN_W-1:0] bin,
                                                  input logic [VAL_W-1:0] value);
    int unsigned     n;
    int unsigned     oldest;
    longint unsigned den;
    longint unsigned acc;
    longint unsigned v;
    hist_mem[bin][slot_of[bin]] = value;
    slot_of[bin] = (slot_of[bin] + 1) % HISTORY_DEPTH;
    if (fill_of[bin] < HISTORY_DEPTH) begin
      fill_of[bin]++;
    end
    n      = fill_of[bin];
    oldest = (slot_of[bin] + HISTORY_DEPTH - n) % HISTORY_DEPTH;
    den    = longint'(n) * n * n * n;
    acc    = 0;
    for (int j = 0; j < n; j++) begin
      v   = hist_mem[bin][(oldest + j) % HISTORY_DEPTH];
      acc += (v * (ramp_q16(j + 1, n) / den)) >> WGT_FRAC;
    end
    return acc[SUM_W-1:0];
  endfunction

  // empty every bin
  task automatic clear_histories();
    for (int b = 0; b < NUM_BINS; b++) begin
      fill_of[b] = 0;
      slot_of[b] = 0;
    end
  endtask

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // offer one input transaction, wait for acceptance, predict, then pace
  task automatic send_item(input logic kind, input logic [BIN_W-1:0] bin,
                           input logic [VAL_W-1:0] value);
    smoothed_t item;
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_bin_index    <= bin;
    in_sample_value <= value;
    do @(posedge clk); while (!in_ready);
    if (kind == KIND_CLEAR) begin
      clear_histories();
      n_clears++;
    end else if (bin < NUM_BINS) begin
      item.bin = bin;
      item.sum = smooth_bin(bin, value);
      smoothed_q.push_back(item);
      n_samples++;
    end
    // bursts of random length, then a random gap unless quiet
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      if (!quiet) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return VAL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // result sink: own stall pattern per window, plus the long hold-off
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (rx_phase == 0) begin
      rx_mode  = $urandom_range(0, 3);
      rx_phase = $urandom_range(20, 120);
    end
    rx_phase--;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 1);
        2:       out_ready <= ((rx_phase % 7) >= 3);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    smoothed_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (smoothed_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result bin %0d value %0d",
                                out_bin, out_smoothed_value));
      end else begin
        want = smoothed_q.pop_front();
        if (out_bin !== want.bin) begin
          flag_mismatch($sformatf("bin: got %0d, want %0d", out_bin, want.bin));
        end
        if (out_smoothed_value !== want.sum) begin
          flag_mismatch($sformatf("bin %0d smoothed value: got %0d, want %0d",
                                  want.bin, out_smoothed_value, want.sum));
        end
      end
    end
  end

  // extremes of each field, clears with junk fields, single-entry history
  task automatic test_directed();
    send_item(KIND_SAMPLE, 7'd0, 16'h0000);
    send_item(KIND_SAMPLE, 7'd127, 16'hFFFF);
    send_item(KIND_SAMPLE, 7'd127, 16'h0000);
    send_item(KIND_SAMPLE, 7'd127, 16'hFFFF);
    send_item(KIND_SAMPLE, 7'd42, 16'hAAAA);
    send_item(KIND_SAMPLE, 7'd85, 16'h5555);
    send_item(KIND_SAMPLE, 7'd42, 16'h5555);
    send_item(KIND_SAMPLE, 7'd85, 16'hAAAA);
    send_item(KIND_CLEAR, 7'd127, 16'hFFFF);
    send_item(KIND_SAMPLE, 7'd127, 16'h0001);
    send_item(KIND_SAMPLE, 7'd42, 16'hFFFF);
    send_item(KIND_CLEAR, 7'd0, 16'h0000);
    send_item(KIND_CLEAR, 7'd85, 16'h1234);
    send_item(KIND_SAMPLE, 7'd0, 16'hFFFF);
  endtask

  // fill one bin past its depth so the ring wraps at full magnitude
  task automatic test_wraparound();
    for (int i = 0; i < HISTORY_DEPTH + 4; i++) begin
      send_item(KIND_SAMPLE, 7'd127, (i % 9 == 5) ? pick_value() : 16'hFFFF);
    end
  endtask

  // result sink holds off while samples keep coming, input must stall
  task automatic test_backpressure();
    quiet        = 1'b1;
    hold_request = 1'b1;
    for (int i = 0; i < 8; i++) begin
      send_item(KIND_SAMPLE, 7'd3, pick_value());
    end
    quiet = 1'b0;
  endtask

  // phases on a couple of hot bins so histories fill and wrap, rare clears
  task automatic test_random();
    logic [BIN_W-1:0] hot_a;
    logic [BIN_W-1:0] hot_b;
    int               r;
    hot_a = BIN_W'($urandom_range(0, NUM_BINS - 1));
    hot_b = BIN_W'($urandom_range(0, NUM_BINS - 1));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 75 == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          hot_a = BIN_W'($urandom_range(0, NUM_BINS - 1));
        end
        hot_b = BIN_W'($urandom_range(0, NUM_BINS - 1));
        quiet = ($urandom_range(0, 2) == 0);
      end
      r = $urandom_range(0, 199);
      if (r < 3) begin
        send_item(KIND_CLEAR, BIN_W'($urandom()), VAL_W'($urandom()));
      end else if (r < 90) begin
        send_item(KIND_SAMPLE, hot_a, pick_value());
      end else if (r < 160) begin
        send_item(KIND_SAMPLE, hot_b, pick_value());
      end else begin
        send_item(KIND_SAMPLE, BIN_W'($urandom_range(0, NUM_BINS - 1)), pick_value());
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    clear_histories();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_wraparound();
    test_backpressure();
    test_random();

    // drain outstanding results, then let the pipeline settle
    in_valid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples and %0d clears, %0d results checked, %0d mismatches",
             n_samples, n_clears, n_results, mismatches);
    $display("included full-depth wraparound and a %0d-cycle result hold-off", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", smoothed_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
